// ----- hdl/box_blur_3x3_edge_aware_macros.svh -----
// Assertion macros for the box blur block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bblur_pkg.sv -----
// Shared types, constants and helpers for the 3x3 box blur.
// No dependencies; imported by the interfaces and every module.
package bblur_pkg;

	localparam int MAX_WIDTH_DEFAULT = 1024;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int PIX_W      = CH_W * NUM_CH;
	localparam int SUM_W      = 12;   // 9 * 255 plus rounding fits
	localparam int N_W        = 4;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [N_W-1:0] N_MAX = 4'd9;

	localparam int IMAGE_WIDTH_RST = 1024;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd1;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// position of a tap inside the 3x3 window, per axis
	localparam logic [1:0] TAP_LO  = 2'd0;
	localparam logic [1:0] TAP_MID = 2'd1;
	localparam logic [1:0] TAP_HI  = 2'd2;

	typedef logic [1:0] slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAP,
		ST_LAST,
		ST_START,
		ST_DIV,
		ST_PUT
	} bblur_state_t;

	// one output pixel to compute: line store slot of its row and window edges
	typedef struct packed {
		slot_t slot;
		logic  top;
		logic  bot;
		logic  left;
		logic  right;
		logic  row_end;
		logic  image_end;
		logic  run_last;
	} emit_t;

	function automatic slot_t slot_next(input slot_t s);
		return (s == 2'd2) ? 2'd0 : slot_t'(s + 2'd1);
	endfunction

	function automatic slot_t slot_prev(input slot_t s);
		return (s == 2'd0) ? 2'd2 : slot_t'(s - 2'd1);
	endfunction

endpackage

// ----- hdl/bblur_if.sv -----
// Valid/ready channel interfaces of the box blur: pixel in, pixel out, config.
// Depends on bblur_pkg for field widths.
interface bblur_in_if import bblur_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            func;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;

	modport source(output valid, func, in_red, in_green, in_blue, input ready);
	modport sink(input valid, func, in_red, in_green, in_blue, output ready);
endinterface

interface bblur_out_if import bblur_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic            row_end;
	logic            image_end;
	logic            run_last;

	modport source(output valid, out_red, out_green, out_blue, row_end, image_end,
		run_last, input ready);
	modport sink(input valid, out_red, out_green, out_blue, row_end, image_end,
		run_last, output ready);
endinterface

interface bblur_cfg_if import bblur_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// ----- hdl/bblur_div.sv -----
// Bit-serial rounding divider for the three colour sums, one quotient bit a cycle.
// Depends on bblur_pkg.
module bblur_div import bblur_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_CH-1:0][SUM_W-1:0] sum,
	input  logic [N_W-1:0]               n,
	output logic                         busy,
	output logic [NUM_CH-1:0][CH_W-1:0]  quo
);

	localparam int CNT_W = $clog2(CH_W);

	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [N_W-1:0]              n_q;
	logic [NUM_CH-1:0][N_W-1:0]  rem_q;
	logic [NUM_CH-1:0][CH_W-1:0] quo_q;

	logic [NUM_CH-1:0][SUM_W-1:0] x;
	logic [NUM_CH-1:0][N_W:0]     t;
	logic [NUM_CH-1:0][N_W:0]     diff;
	logic [NUM_CH-1:0]            ge;
	logic [NUM_CH-1:0][N_W-1:0]   rem_d;
	logic [NUM_CH-1:0][CH_W-1:0]  quo_d;

	// (sum + n/2) / n is round half up; mean <= 255 so the top bits start below n
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			x[ch]     = sum[ch] + SUM_W'(n >> 1);
			t[ch]     = {rem_q[ch], quo_q[ch][CH_W-1]};
			diff[ch]  = t[ch] - {1'b0, n_q};
			ge[ch]    = (t[ch] >= {1'b0, n_q});
			rem_d[ch] = ge[ch] ? diff[ch][N_W-1:0] : t[ch][N_W-1:0];
			quo_d[ch] = {quo_q[ch][CH_W-2:0], ge[ch]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(CH_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				rem_q[ch] <= x[ch][SUM_W-1:CH_W];
				quo_q[ch] <= x[ch][CH_W-1:0];
			end
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ----- hdl/box_blur_3x3_edge_aware.sv -----
// Streaming 3x3 box blur of an RGB image, neighbours outside the image left out.
// Depends on bblur_pkg, bblur_if and bblur_div.
//
// Channels: cfg writes image_width (index 0) or image_height (index 1) and
// restarts the image; it is always ready and must be written only while
// idle, which the block itself does not enforce. pix_in takes pixels in
// raster order (func 0) or drain beats (func 1). pix_out gives blurred pixels
// in raster order, one row behind the input; drain beats then give the last
// row one pixel each. A beat that yields nothing leaves the block idle. Each
// result is read from its window taps on the single line store read port,
// summed, passed through the bit-serial divider and loaded into the output
// register. A pixel that closes a row yields two results.
// pix_in.ready is high only while no result is being computed; the last
// result may still sit in the output register while the next beat is taken.
// A stalled receiver holds the output register and stops the sequencer
// before it loads the next result.
// Reset: width min(MAX_WIDTH, 1024), height 1, position counters cleared;
// the line stores hold no reset and are read only where already written.
`include "box_blur_3x3_edge_aware_macros.svh"

module box_blur_3x3_edge_aware import bblur_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	bblur_cfg_if.sink    cfg,
	bblur_in_if.sink     pix_in,
	bblur_out_if.source  pix_out
);

	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int MEM_DEPTH = 3 * MAX_WIDTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int RST_W     = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;

	localparam logic [AW-1:0] BASE1 = AW'(MAX_WIDTH);
	localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_WIDTH);

	bblur_state_t state_q, state_d;

	logic [WW-1:0]      eff_w_q;
	logic [IMG_H_W-1:0] eff_h_q;
	logic [IMG_H_W-1:0] in_row_q;
	logic [CW-1:0]      in_col_q;
	slot_t              row_rot_q;
	logic [WW-1:0]      drain_col_q;
	logic               input_done_q;

	emit_t         cur_q, nxt_q;
	logic [CW-1:0] cur_col_q, nxt_col_q;
	logic          has_nxt_q;

	logic [1:0] tr_q, tc_q;

	logic [PIX_W-1:0] mem [MEM_DEPTH];
	logic [PIX_W-1:0] rd_data_s1;
	logic             rd_vld_s1;

	logic [NUM_CH-1:0][SUM_W-1:0] sum_q;
	logic [N_W-1:0]               n_q;

	logic                        out_vld_q;
	logic [NUM_CH-1:0][CH_W-1:0] out_pix_q;
	logic                        out_row_end_q, out_image_end_q, out_run_last_q;

	logic                        div_start, div_busy;
	logic [NUM_CH-1:0][CH_W-1:0] div_quo;

	logic          cfg_wr, in_acc, pix_acc, drn_acc;
	logic          has_e0, has_e1, col_last, row_last;
	emit_t         e0, e1, ed;
	logic          tap_last, row_ok, col_ok, rd_en;
	slot_t         rd_slot;
	logic [CW:0]   col_ext;
	logic [AW-1:0] rd_base, rd_addr, wr_base, wr_addr;
	logic          next_emit, load_out, sum_clr;
	logic [IMG_W_W-1:0] cfg_w;
	logic [WW-1:0]      cfg_w_eff;

	// ---------------- beat decode ----------------
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;
	assign in_acc    = pix_in.valid && pix_in.ready;
	assign pix_acc   = in_acc && (pix_in.func == FUNC_PIXEL) && !input_done_q;
	assign drn_acc   = in_acc && (pix_in.func == FUNC_DRAIN) && input_done_q &&
		(drain_col_q < eff_w_q);

	assign col_last = (WW'(in_col_q) == (eff_w_q - 1'b1));
	assign row_last = (({1'b0, in_row_q} + 17'd1) >= {1'b0, eff_h_q});
	assign has_e0   = (in_row_q != '0) && (in_col_q != '0);
	assign has_e1   = (in_row_q != '0) && col_last;

	assign cfg_w     = cfg.wdata[IMG_W_W-1:0];
	assign cfg_w_eff = (cfg_w == '0) ? WW'(1) :
		(({21'd0, cfg_w} > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w));

	// pixel (r,c) emits (r-1,c-1), and (r-1,W-1) at the row end
	always_comb begin
		e0.slot      = slot_prev(row_rot_q);
		e0.top       = (in_row_q > 16'd1);
		e0.bot       = 1'b1;
		e0.left      = (in_col_q > CW'(1));
		e0.right     = 1'b1;
		e0.row_end   = 1'b0;
		e0.image_end = 1'b0;
		e0.run_last  = !has_e1;

		e1           = e0;
		e1.left      = (eff_w_q > WW'(1));
		e1.right     = 1'b0;
		e1.row_end   = 1'b1;
		e1.run_last  = 1'b1;

		ed.slot      = slot_prev(row_rot_q);
		ed.top       = (eff_h_q > 16'd1);
		ed.bot       = 1'b0;
		ed.left      = (drain_col_q != '0);
		ed.right     = (({1'b0, drain_col_q} + 1'b1) < {1'b0, eff_w_q});
		ed.row_end   = (drain_col_q == (eff_w_q - 1'b1));
		ed.image_end = ed.row_end;
		ed.run_last  = 1'b1;
	end

	// ---------------- sequencer ----------------
	assign tap_last = (tr_q == TAP_HI) && (tc_q == TAP_HI);

	always_comb begin
		state_d       = state_q;
		pix_in.ready  = 1'b0;
		next_emit     = 1'b0;
		load_out      = 1'b0;
		div_start     = 1'b0;
		sum_clr       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pix_in.ready = 1'b1;
				sum_clr      = 1'b1;
				if (drn_acc || (pix_acc && (has_e0 || has_e1))) begin
					state_d = ST_TAP;
				end
			end
			ST_TAP: begin
				if (tap_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_START;
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				sum_clr = 1'b1;
				if (!out_vld_q || pix_out.ready) begin
					load_out = 1'b1;
					if (has_nxt_q) begin
						next_emit = 1'b1;
						state_d   = ST_TAP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- image position ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q      <= WW'(RST_W);
			eff_h_q      <= IMAGE_HEIGHT_RST;
			in_row_q     <= '0;
			in_col_q     <= '0;
			row_rot_q    <= '0;
			drain_col_q  <= '0;
			input_done_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_IMAGE_WIDTH: begin
					eff_w_q <= cfg_w_eff;
				end
				REG_IMAGE_HEIGHT: begin
					eff_h_q <= (cfg.wdata == '0) ? IMAGE_HEIGHT_RST : cfg.wdata;
				end
				default: ;
			endcase
			if (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT) begin
				in_row_q     <= '0;
				in_col_q     <= '0;
				row_rot_q    <= '0;
				drain_col_q  <= '0;
				input_done_q <= 1'b0;
			end
		end else begin
			if (pix_acc) begin
				if (col_last) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 1'b1;
					row_rot_q <= slot_next(row_rot_q);
					if (row_last) begin
						input_done_q <= 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (drn_acc) begin
				drain_col_q <= drain_col_q + 1'b1;
			end
		end
	end

	// ---------------- pending results ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (drn_acc) begin
				cur_q     <= ed;
				cur_col_q <= CW'(drain_col_q);
			end else if (pix_acc) begin
				nxt_q     <= e1;
				nxt_col_q <= CW'(eff_w_q - 1'b1);
				if (has_e0) begin
					cur_q     <= e0;
					cur_col_q <= in_col_q - 1'b1;
				end else begin
					cur_q     <= e1;
					cur_col_q <= CW'(eff_w_q - 1'b1);
				end
			end
		end else if (next_emit) begin
			cur_q     <= nxt_q;
			cur_col_q <= nxt_col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_nxt_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			has_nxt_q <= pix_acc && has_e0 && has_e1;
		end else if (next_emit) begin
			has_nxt_q <= 1'b0;
		end
	end

	// ---------------- window reads ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q <= TAP_LO;
			tc_q <= TAP_LO;
		end else if (state_q == ST_TAP) begin
			if (tc_q == TAP_HI) begin
				tc_q <= TAP_LO;
				tr_q <= tap_last ? TAP_LO : 2'(tr_q + 2'd1);
			end else begin
				tc_q <= tc_q + 2'd1;
			end
		end
	end

	always_comb begin
		case (tr_q)
			TAP_LO:  begin row_ok = cur_q.top; rd_slot = slot_prev(cur_q.slot); end
			TAP_MID: begin row_ok = 1'b1;      rd_slot = cur_q.slot;            end
			TAP_HI:  begin row_ok = cur_q.bot; rd_slot = slot_next(cur_q.slot); end
			default: begin row_ok = 1'b0;      rd_slot = cur_q.slot;            end
		endcase
		case (tc_q)
			TAP_LO:  col_ok = cur_q.left;
			TAP_MID: col_ok = 1'b1;
			TAP_HI:  col_ok = cur_q.right;
			default: col_ok = 1'b0;
		endcase
		case (rd_slot)
			2'd1:    rd_base = BASE1;
			2'd2:    rd_base = BASE2;
			default: rd_base = '0;
		endcase
		case (row_rot_q)
			2'd1:    wr_base = BASE1;
			2'd2:    wr_base = BASE2;
			default: wr_base = '0;
		endcase
	end

	// column offset wraps when off the left edge, but such a tap is never read
	assign col_ext = {1'b0, cur_col_q} + (CW+1)'(tc_q) - (CW+1)'(1);
	assign rd_addr = rd_base + AW'(col_ext[CW-1:0]);
	assign wr_addr = wr_base + AW'(in_col_q);
	assign rd_en   = (state_q == ST_TAP) && row_ok && col_ok;

	// the pixel is written on its accept beat, before any read of its window
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			mem[wr_addr] <= {pix_in.in_red, pix_in.in_green, pix_in.in_blue};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	// ---------------- accumulate ----------------
	always_ff @(posedge clk) begin
		if (sum_clr) begin
			sum_q <= '0;
			n_q   <= '0;
		end else if (rd_vld_s1) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				sum_q[ch] <= sum_q[ch] +
					SUM_W'(rd_data_s1[(NUM_CH-1-ch)*CH_W +: CH_W]);
			end
			n_q <= n_q + 1'b1;
		end
	end

	bblur_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (sum_q),
		.n      (n_q),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pix_q       <= div_quo;
			out_row_end_q   <= cur_q.row_end;
			out_image_end_q <= cur_q.image_end;
			out_run_last_q  <= cur_q.run_last;
		end
	end

	assign pix_out.valid     = out_vld_q;
	assign pix_out.out_red   = out_pix_q[0];
	assign pix_out.out_green = out_pix_q[1];
	assign pix_out.out_blue  = out_pix_q[2];
	assign pix_out.row_end   = out_row_end_q;
	assign pix_out.image_end = out_image_end_q;
	assign pix_out.run_last  = out_run_last_q;

	// ---------------- checks ----------------
	`BB_ASSERT_IMP(a_idle_div_quiet, pix_in.ready, !div_busy, "divider busy while taking a beat")
	`BB_ASSERT_IMP(a_div_n_range, div_start, (n_q != '0) && (n_q <= N_MAX), "tap count out of range")
	`BB_ASSERT_IMP(a_rd_in_store, rd_en, ({1'b0, rd_addr} < (AW+1)'(MEM_DEPTH)), "read past line store")
	`BB_ASSERT_NXT(a_drain_bound, drn_acc, (drain_col_q <= eff_w_q), "drain column past row")

endmodule

// ----- tb/tb_box_blur_3x3_edge_aware.sv -----
// Self-checking testbench for the 3x3 edge-aware box blur: directed and random images.
// Predicts every blurred pixel from its own copy of the line stores and compares beats.
// Depends on bblur_pkg, bblur_if and the box_blur_3x3_edge_aware RTL.
module tb_box_blur_3x3_edge_aware import bblur_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = MAX_WIDTH_DEFAULT;

	// indexes that map to no register: a write must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            row_end;
		logic            image_end;
		logic            run_last;
	} blur_px_t;

	logic clk = 1'b0;
	logic arst_n;

	bblur_cfg_if cfg_bus ();
	bblur_in_if  pix_in_bus ();
	bblur_out_if pix_out_bus ();

	box_blur_3x3_edge_aware uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.pix_in(pix_in_bus),
		.pix_out(pix_out_bus)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [PIX_W-1:0]   frame_lines [3*MAX_W];
	logic [IMG_W_W-1:0] width_reg;
	logic [IMG_H_W-1:0] height_reg;
	int unsigned        pix_row, pix_col, line_rot, flush_col;
	bit                 frame_done;

	blur_px_t    blur_q [$];
	blur_px_t    seen_px, due_px;
	int unsigned err_count = 0;
	int unsigned result_count = 0;
	bit          idle_on = 1'b1;

	function automatic int unsigned eff_width();
		int unsigned w;
		w = 32'(width_reg);
		if (w == 0) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : 32'(height_reg);
	endfunction

	function automatic void restart_image();
		pix_row = 0;
		pix_col = 0;
		line_rot = 0;
		flush_col = 0;
		frame_done = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = data[IMG_W_W-1:0];
			restart_image();
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = data;
			restart_image();
		end
	endfunction

	// mean of the in-image part of the window around (orow, ocol); slot holds orow
	function automatic void predict_blur(input int unsigned orow, ocol, slot, w, h,
			input bit last_of_beat);
		int unsigned rows [3];
		int unsigned nrows, n, acc_r, acc_g, acc_b, i;
		int col, dc;
		logic [PIX_W-1:0] px;
		blur_px_t due;
		nrows = 0;
		n = 0;
		acc_r = 0;
		acc_g = 0;
		acc_b = 0;
		if (orow >= 1) begin
			rows[nrows] = (slot + 2) % 3;
			nrows++;
		end
		rows[nrows] = slot;
		nrows++;
		if (orow + 1 < h) begin
			rows[nrows] = (slot + 1) % 3;
			nrows++;
		end
		for (i = 0; i < nrows; i++) begin
			for (dc = -1; dc <= 1; dc++) begin
				col = int'(ocol) + dc;
				if (col >= 0 && col < int'(w)) begin
					px = frame_lines[rows[i] * MAX_W + col];
					acc_r += 32'(px[2*CH_W +: CH_W]);
					acc_g += 32'(px[CH_W +: CH_W]);
					acc_b += 32'(px[0 +: CH_W]);
					n++;
				end
			end
		end
		// round half up: floor((2*sum + n) / (2*n))
		due.red = CH_W'((2 * acc_r + n) / (2 * n));
		due.green = CH_W'((2 * acc_g + n) / (2 * n));
		due.blue = CH_W'((2 * acc_b + n) / (2 * n));
		due.row_end = (ocol == w - 1);
		due.image_end = (ocol == w - 1) && (orow == h - 1);
		due.run_last = last_of_beat;
		blur_q.push_back(due);
	endfunction

	function automatic void model_pixel(input logic [CH_W-1:0] r, g, b);
		int unsigned w, h, ps;
		bit closes_row;
		w = eff_width();
		h = eff_height();
		if (frame_done || pix_col >= w) return;
		frame_lines[line_rot * MAX_W + pix_col] = {r, g, b};
		closes_row = (pix_col == w - 1);
		if (pix_row >= 1) begin
			ps = (line_rot + 2) % 3;
			if (pix_col >= 1) predict_blur(pix_row - 1, pix_col - 1, ps, w, h, !closes_row);
			if (closes_row) predict_blur(pix_row - 1, w - 1, ps, w, h, 1'b1);
		end
		if (closes_row) begin
			pix_col = 0;
			pix_row++;
			line_rot = (line_rot + 1) % 3;
			if (pix_row >= h) frame_done = 1'b1;
		end else begin
			pix_col++;
		end
	endfunction

	function automatic void model_drain();
		int unsigned w, h;
		w = eff_width();
		h = eff_height();
		if (!frame_done || flush_col >= w) return;
		predict_blur(h - 1, flush_col, (line_rot + 2) % 3, w, h, 1'b1);
		flush_col++;
	endfunction

	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: rand_chan = '0;
			1: rand_chan = '1;
			default: rand_chan = CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_error(input string msg);
		if (err_count < 100) $display("ERROR at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got, want);
		if (got != want)
			report_error($sformatf("result %0d %s: got %0d, expected %0d",
				result_count, name, got, want));
	endtask

	// config valid is left high after a write; the next beat or idle wait drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.wdata <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		apply_reg(idx, data);
	endtask

	task automatic send_beat(input logic f, input logic [CH_W-1:0] r, g, b);
		cfg_bus.valid <= 1'b0;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			pix_in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.func <= f;
		pix_in_bus.in_red <= r;
		pix_in_bus.in_green <= g;
		pix_in_bus.in_blue <= b;
		do @(posedge clk); while (!pix_in_bus.ready);
		if (f == FUNC_PIXEL) model_pixel(r, g, b);
		else model_drain();
	endtask

	task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
		send_beat(FUNC_PIXEL, r, g, b);
	endtask

	// channel content of a drain beat is don't-care, so randomise it
	task automatic send_drain();
		send_beat(FUNC_DRAIN, rand_chan(), rand_chan(), rand_chan());
	endtask

	// block is idle once every expected beat is out and the sequencer has settled
	task automatic wait_idle();
		pix_in_bus.valid <= 1'b0;
		cfg_bus.valid <= 1'b0;
		while (blur_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_drain();
		send_pixel(8'd255, 8'd0, 8'd128);
		send_pixel(8'd0, 8'd255, 8'd1);
	endtask

	// width 0 with junk in the upper bits and height 0 both act as 1
	task automatic test_single_pixel();
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 16'hF800);
		write_reg(REG_IMAGE_HEIGHT, 16'h0000);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd2, 8'd3);
		send_drain();
		send_drain();
	endtask

	task automatic test_small_image();
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 16'd2);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd1, 8'd254, 8'd128);
		send_pixel(8'd254, 8'd1, 8'd127);
		send_drain();
		send_drain();
	endtask

	task automatic test_restart_on_write();
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'd2);
		send_pixel(rand_chan(), rand_chan(), rand_chan());
		send_pixel(rand_chan(), rand_chan(), rand_chan());
		send_drain();
		wait_idle();
		// a spare index leaves the image position alone
		write_reg(CFG_SPARE_HI, 16'hFFFF);
		send_pixel(rand_chan(), rand_chan(), rand_chan());
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, 16'd2);
		repeat (6) send_pixel(rand_chan(), rand_chan(), rand_chan());
		repeat (3) send_drain();
	endtask

	// width above the limit clamps to MAX_W; one full row and a bit of the second
	task automatic test_full_width();
		int unsigned k;
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 16'd2047);
		write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
		for (k = 0; k < MAX_W + 3; k++) begin
			if ($urandom_range(0, 31) == 0) send_drain();
			send_pixel(rand_chan(), rand_chan(), rand_chan());
		end
	endtask

	task automatic test_random_images(input int unsigned item_goal, input bit allow_idle);
		int unsigned sent, w, h, npix, ndrain, k;
		logic [CFG_DATA_W-1:0] wdat, hdat;
		bit broken;
		sent = 0;
		while (sent < item_goal) begin
			wait_idle();
			idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: wdat = 16'd0;
				1: wdat = $urandom_range(0, 1) ? 16'd1024 : 16'($urandom_range(1025, 2047));
				2: wdat = 16'($urandom_range(9, 40));
				default: wdat = 16'($urandom_range(1, 8));
			endcase
			wdat[CFG_DATA_W-1:IMG_W_W] = (CFG_DATA_W-IMG_W_W)'($urandom);
			case ($urandom_range(0, 9))
				0: hdat = 16'd0;
				1: hdat = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(7, 65535));
				default: hdat = 16'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 3))
				0: begin
					write_reg(REG_IMAGE_WIDTH, wdat);
					write_reg(REG_IMAGE_HEIGHT, hdat);
				end
				1: begin
					write_reg(REG_IMAGE_HEIGHT, hdat);
					write_reg(REG_IMAGE_WIDTH, wdat);
				end
				2: write_reg(REG_IMAGE_WIDTH, wdat);
				default: write_reg(REG_IMAGE_HEIGHT, hdat);
			endcase
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
			w = eff_width();
			h = eff_height();
			npix = w * h;
			// wide images stay in their first row, tall ones are cut after a few rows
			if (w > 40) npix = $urandom_range(1, 60);
			else if (npix > 240) npix = w * $urandom_range(2, 5) + $urandom_range(0, w - 1);
			broken = ($urandom_range(0, 4) == 0);
			if (broken) npix = $urandom_range(0, npix);
			for (k = 0; k < npix; k++) begin
				if ($urandom_range(0, 15) == 0) send_drain();
				send_pixel(rand_chan(), rand_chan(), rand_chan());
				sent++;
			end
			if (npix == w * h) begin
				ndrain = broken ? $urandom_range(0, w) : w;
				for (k = 0; k < ndrain; k++) begin
					send_drain();
					sent++;
				end
				if ($urandom_range(0, 2) == 0) begin
					send_pixel(rand_chan(), rand_chan(), rand_chan());
					send_drain();
				end
			end
		end
	endtask

	// result side: random stall bursts on ready while idling is on
	initial begin
		pix_out_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				pix_out_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			pix_out_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (pix_out_bus.valid && pix_out_bus.ready) begin
			seen_px.red = pix_out_bus.out_red;
			seen_px.green = pix_out_bus.out_green;
			seen_px.blue = pix_out_bus.out_blue;
			seen_px.row_end = pix_out_bus.row_end;
			seen_px.image_end = pix_out_bus.image_end;
			seen_px.run_last = pix_out_bus.run_last;
			if (blur_q.size() == 0) begin
				report_error($sformatf("result beat with nothing expected: rgb %0d %0d %0d",
					seen_px.red, seen_px.green, seen_px.blue));
			end else begin
				due_px = blur_q.pop_front();
				check_field("out_red", 32'(seen_px.red), 32'(due_px.red));
				check_field("out_green", 32'(seen_px.green), 32'(due_px.green));
				check_field("out_blue", 32'(seen_px.blue), 32'(due_px.blue));
				check_field("row_end", 32'(seen_px.row_end), 32'(due_px.row_end));
				check_field("image_end", 32'(seen_px.image_end), 32'(due_px.image_end));
				check_field("run_last", 32'(seen_px.run_last), 32'(due_px.run_last));
			end
			result_count++;
		end
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_IMAGE_WIDTH;
		cfg_bus.wdata <= '0;
		pix_in_bus.valid <= 1'b0;
		pix_in_bus.func <= FUNC_PIXEL;
		pix_in_bus.in_red <= '0;
		pix_in_bus.in_green <= '0;
		pix_in_bus.in_blue <= '0;
		for (int i = 0; i < 3 * MAX_W; i++) frame_lines[i] = '0;
		width_reg = IMG_W_W'(IMAGE_WIDTH_RST);
		height_reg = IMAGE_HEIGHT_RST;
		restart_image();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_single_pixel();
		test_small_image();
		test_restart_on_write();
		test_full_width();
		test_random_images(700, 1'b1);
		test_random_images(150, 1'b0);
		idle_on = 1'b0;
		wait_idle();

		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
